@@ rtl/dnc_pkg.sv @@
package dnc_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TSUM,
    ST_TADD,
    ST_DELTA,
    ST_MAG,
    ST_CMP,
    ST_DIV1,
    ST_PHASE,
    ST_DIFF,
    ST_DIV2,
    ST_AVG,
    ST_OUT
  } state_t;

  // Result action codes
  localparam logic [1:0] ACT_TICK       = 2'd0;
  localparam logic [1:0] ACT_HARD       = 2'd1;
  localparam logic [1:0] ACT_SLEW_DEF   = 2'd2;
  localparam logic [1:0] ACT_SLEW_TUNED = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_DIV     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_AFTER  = 2'd3;

  // Register reset values
  localparam logic [15:0] RST_HARD_LIMIT   = 16'd120;
  localparam logic [23:0] RST_SLEW_DIV     = 24'd1024000;
  localparam logic [31:0] RST_DEFAULT_STEP = 32'd4294967;
  localparam logic [31:0] RST_VALID_AFTER  = 32'd3155673600;

  // Divider: 64-bit dividend, 32-bit divisor, two quotient bits per cycle
  localparam int DIV_ITERS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

endpackage

@@ rtl/dnc_if.sv @@
interface dnc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] server_timestamp;

  modport source (output valid, output func, output server_timestamp, input ready);
  modport sink (input valid, input func, input server_timestamp, output ready);
endinterface

interface dnc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] clock_now;
  logic [1:0]  action;
  logic        time_valid;

  modport source (output valid, output clock_now, output action, output time_valid,
                  input ready);
  modport sink (input valid, input clock_now, input action, input time_valid,
                output ready);
endinterface

@@ rtl/disciplined_ntp_clock.sv @@
// Disciplined 32.32 timestamp clock.
// in_ch carries one beat per event: func 0 is one elapsed tick, func 1 is a
// server timestamp sample. out_ch returns exactly one beat per input beat with
// the local time after the event, the action taken and a time-valid flag.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must write it only while idle, as the block does not enforce this.
// Throughput: one item at a time. A tick passes TSUM and TADD; a sample that
// sets the clock hard passes DELTA, MAG and CMP; a slewed sample runs one
// 64-by-32 division and, when a rate can be measured, a second one. The
// shared divider retires two quotient bits per cycle for both divisions.
// in_ch.ready is high only while the sequencer is idle.
// Results sit in an output register: a new item is accepted while the last
// result still waits; if the receiver stalls, the sequencer holds its next
// result in its final state until the register frees up.
// Reset (rst, synchronous) loads the register defaults, zeroes the clock,
// steering, last sample and tick count, and sets the step to its default.
module disciplined_ntp_clock
  import dnc_pkg::*;
#(
  parameter int TICK_COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dnc_in_if.sink                in_ch,
  dnc_out_if.source             out_ch
);

  state_t state, state_next;

  // Configuration registers
  logic [15:0] hard_limit;
  logic [23:0] slew_div;
  logic [31:0] default_step;
  logic [31:0] valid_after;

  // Clock state
  logic [63:0] clock_value;
  logic [63:0] rate_step;
  logic [63:0] phase_steer;
  logic [63:0] last_sample;
  logic [TICK_COUNT_BITS-1:0] ticks_since;
  logic        sample_seen;

  // Working registers
  logic [63:0] srv;
  logic [63:0] scratch;
  logic        delta_neg;
  logic [1:0]  action_r;

  // Divider registers
  logic [63:0]          div_quo;
  logic [31:0]          div_rem;
  logic [31:0]          div_den;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [63:0]          div_quo_next;
  logic [31:0]          div_rem_next;

  // Output register
  logic        out_valid;
  logic [63:0] out_clock;
  logic [1:0]  out_action;
  logic        out_tvalid;

  // Shared adder
  logic [63:0] add_a, add_b, add_sum;
  logic        add_cin;

  logic accept, out_free, div_last, hard_hit, no_rate;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign div_last = (div_cnt == DIV_CNT_W'(DIV_ITERS - 1));
  assign hard_hit = (scratch > {16'd0, hard_limit, 32'd0});
  assign no_rate  = !sample_seen || (ticks_since == '0);
  assign add_sum  = add_a + add_b + 64'(add_cin);

  assign in_ch.ready       = (state == ST_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.clock_now  = out_clock;
  assign out_ch.action     = out_action;
  assign out_ch.time_valid = out_tvalid;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = in_ch.func ? ST_DELTA : ST_TSUM;
      ST_TSUM:  state_next = ST_TADD;
      ST_TADD:  state_next = ST_OUT;
      ST_DELTA: state_next = ST_MAG;
      ST_MAG:   state_next = ST_CMP;
      ST_CMP:   state_next = hard_hit ? ST_OUT : ST_DIV1;
      ST_DIV1:  if (div_last) state_next = ST_PHASE;
      ST_PHASE: state_next = no_rate ? ST_OUT : ST_DIFF;
      ST_DIFF:  state_next = ST_DIV2;
      ST_DIV2:  if (div_last) state_next = ST_AVG;
      ST_AVG:   state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Adder operand select
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    case (state)
      ST_TSUM: begin
        add_a = rate_step;
        add_b = phase_steer;
      end
      ST_TADD: begin
        add_a = clock_value;
        add_b = scratch;
      end
      ST_DELTA: begin
        add_a   = clock_value;
        add_b   = ~srv;
        add_cin = 1'b1;
      end
      ST_MAG: begin
        add_a   = delta_neg ? ~scratch : scratch;
        add_cin = delta_neg;
      end
      ST_PHASE: begin
        add_a   = delta_neg ? div_quo : ~div_quo;
        add_cin = !delta_neg;
      end
      ST_DIFF: begin
        add_a   = srv;
        add_b   = ~last_sample;
        add_cin = 1'b1;
      end
      ST_AVG: begin
        add_a   = {1'b0, rate_step[63:1]};
        add_b   = {1'b0, div_quo[63:1]};
        add_cin = rate_step[0] & div_quo[0];
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
      end
    endcase
  end

  // Two restoring division steps per cycle
  always_comb begin
    logic [32:0] part;
    div_quo_next = div_quo;
    div_rem_next = div_rem;
    for (int i = 0; i < 2; i++) begin
      part         = {div_rem_next, div_quo_next[63]};
      div_quo_next = {div_quo_next[62:0], 1'b0};
      if (part >= {1'b0, div_den}) begin
        div_rem_next    = 32'(part - {1'b0, div_den});
        div_quo_next[0] = 1'b1;
      end else begin
        div_rem_next = part[31:0];
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hard_limit   <= RST_HARD_LIMIT;
      slew_div     <= RST_SLEW_DIV;
      default_step <= RST_DEFAULT_STEP;
      valid_after  <= RST_VALID_AFTER;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HARD_LIMIT:   hard_limit   <= cfg_data[15:0];
        CFG_SLEW_DIV:     slew_div     <= cfg_data[23:0];
        CFG_DEFAULT_STEP: default_step <= cfg_data[31:0];
        CFG_VALID_AFTER:  valid_after  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Clock state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_value <= '0;
      rate_step   <= 64'(RST_DEFAULT_STEP);
      phase_steer <= '0;
      last_sample <= '0;
      ticks_since <= '0;
      sample_seen <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (accept) srv <= in_ch.server_timestamp;
        ST_TSUM: scratch <= add_sum;
        ST_TADD: begin
          clock_value <= add_sum;
          action_r    <= ACT_TICK;
          if (!(&ticks_since)) ticks_since <= ticks_since + 1'b1;
        end
        ST_DELTA: begin
          scratch   <= add_sum;
          delta_neg <= add_sum[63];
        end
        ST_MAG: scratch <= add_sum;
        ST_CMP: begin
          if (hard_hit) begin
            clock_value <= srv;
            rate_step   <= 64'(default_step);
            phase_steer <= '0;
            action_r    <= ACT_HARD;
            last_sample <= srv;
            sample_seen <= 1'b1;
            ticks_since <= '0;
          end else begin
            div_quo <= scratch;
            div_rem <= '0;
            div_den <= (slew_div == '0) ? 32'd1 : 32'(slew_div);
            div_cnt <= '0;
          end
        end
        ST_DIV1, ST_DIV2: begin
          div_quo <= div_quo_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt + 1'b1;
        end
        ST_PHASE: begin
          phase_steer <= add_sum;
          if (no_rate) begin
            rate_step   <= 64'(default_step);
            action_r    <= ACT_SLEW_DEF;
            last_sample <= srv;
            sample_seen <= 1'b1;
            ticks_since <= '0;
          end
        end
        ST_DIFF: begin
          div_quo <= add_sum;
          div_rem <= '0;
          div_den <= 32'(ticks_since);
          div_cnt <= '0;
        end
        ST_AVG: begin
          rate_step   <= add_sum;
          action_r    <= ACT_SLEW_TUNED;
          last_sample <= srv;
          sample_seen <= 1'b1;
          ticks_since <= '0;
        end
        default: ;
      endcase
    end
  end

  // Output register: load the result, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid  <= 1'b1;
      out_clock  <= clock_value;
      out_action <= action_r;
      out_tvalid <= (clock_value[63:32] > valid_after);
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/dnc_checker.sv @@
module dnc_checker
  import dnc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_clock_now,
  input logic [1:0]  out_action
);

  // One item at a time: ready stays low after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input accepted again too soon");

  // A new result is only loaded while the sequencer is busy
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_clock_now)
      && $stable(out_action))
    else $error("stalled result beat changed");

  // A valid result carries an action code in range
  a_tick_action: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_action == ACT_TICK || out_action == ACT_HARD
      || out_action == ACT_SLEW_DEF || out_action == ACT_SLEW_TUNED)
    else $error("bad action code");

endmodule

bind disciplined_ntp_clock dnc_checker u_dnc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_clock_now (out_ch.clock_now),
  .out_action    (out_ch.action)
);
